/* rtl/core/sma_pkg.sv */
`default_nettype none
package sma_pkg;
   localparam int STACK_DEPTH = 64;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int WORD_W = 64;

   localparam logic [4:0] FUNC_PUSH = 5'd0;
   localparam logic [4:0] FUNC_POP = 5'd1;
   localparam logic [4:0] FUNC_LAST = 5'd17;

   localparam logic [1:0] GRP_ADD = 2'd0;
   localparam logic [1:0] GRP_SUB = 2'd1;
   localparam logic [1:0] GRP_MUL = 2'd2;
   localparam logic [1:0] GRP_DIV = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;
   localparam logic [1:0] ST_DIVZ = 2'd3;

   // one step of restoring division, handed from cell to cell
   typedef struct packed {
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] quo;
      logic [WORD_W-1:0] dvs;
   } div_word_type;

   function automatic logic [WORD_W-1:0] sext_w(input logic [WORD_W-1:0] x,
                                                input logic [1:0] wsel);
      logic [WORD_W-1:0] r;
      begin
         case (wsel)
            2'd0: r = {{56{x[7]}}, x[7:0]};
            2'd1: r = {{48{x[15]}}, x[15:0]};
            2'd2: r = {{32{x[31]}}, x[31:0]};
            default: r = x;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

/* rtl/core/sma_if.sv */
`default_nettype none
interface sma_req_if;
   logic valid;
   logic ready;
   logic [4:0] func;
   logic signed [63:0] push_value;
   modport source (output valid, func, push_value, input ready);
   modport sink (input valid, func, push_value, output ready);
endinterface

interface sma_rsp_if;
   logic valid;
   logic ready;
   logic signed [63:0] top_value;
   logic [6:0] depth;
   logic [1:0] status;
   modport source (output valid, top_value, depth, status, input ready);
   modport sink (input valid, top_value, depth, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/sma_div_cell.sv */
`default_nettype none
module sma_div_cell
   import sma_pkg::*;
(
   input wire logic clock,
   input wire logic step_en,
   input wire div_word_type d_in,
   output div_word_type d_out
);
   div_word_type d_ff;
   logic [WORD_W:0] trial;
   logic [WORD_W-1:0] shifted;
   div_word_type d_in_c;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      shifted = {d_in.rem[WORD_W-2:0], d_in.quo[WORD_W-1]};
      trial = {1'b0, shifted} - {1'b0, d_in.dvs};
      d_in_c.dvs = d_in.dvs;
      if (!trial[WORD_W] || d_in.rem[WORD_W-1]) begin
         d_in_c.rem = trial[WORD_W-1:0];
         d_in_c.quo = {d_in.quo[WORD_W-2:0], 1'b1};
      end else begin
         d_in_c.rem = shifted;
         d_in_c.quo = {d_in.quo[WORD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         d_ff <= d_in_c;
      end
   end

   assign d_out = d_ff;
endmodule
`default_nettype wire

/* rtl/core/sma_div_chain.sv */
`default_nettype none
module sma_div_chain
   import sma_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [WORD_W-1:0] dividend,
   input wire logic [WORD_W-1:0] divisor,
   output logic done,
   output logic [WORD_W-1:0] quotient
);
   localparam int NCELL = 4;
   localparam int NPASS = WORD_W / NCELL;
   localparam int PW = $clog2(NPASS + 1);
   localparam int PHW = $clog2(NCELL + 1);

   div_word_type link [NCELL+1];
   div_word_type loop_ff;
   logic busy_ff;
   logic [PW-1:0] pass_ff;

   // row of four cells, the loop register feeds the head each pass
   assign link[0] = loop_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      sma_div_cell u_cell (
         .clock(clock),
         .step_en(1'b1),
         .d_in(link[g]),
         .d_out(link[g+1])
      );
   end

   // cells are registered, so a pass steps through the row cell by cell; the
   // phase counter waits until the tail is valid after the last cell loads,
   // and only then does the loop register capture it
   logic [PHW-1:0] phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done <= 1'b0;
         pass_ff <= '0;
         phase_ff <= '0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            pass_ff <= '0;
            phase_ff <= '0;
            loop_ff.rem <= '0;
            loop_ff.quo <= dividend;
            loop_ff.dvs <= divisor;
         end else if (busy_ff) begin
            phase_ff <= phase_ff + 1'b1;
            if (phase_ff == PHW'(NCELL)) begin
               phase_ff <= '0;
               loop_ff <= link[NCELL];
               if (pass_ff == PW'(NPASS - 1)) begin
                  busy_ff <= 1'b0;
                  done <= 1'b1;
                  quotient <= link[NCELL].quo;
               end
               pass_ff <= pass_ff + 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/stack_machine_alu.sv */
// states: push READ, OUT; pop, errors READ, EXEC, OUT; add, sub READ,
//   EXEC, MUL, WB, OUT; mul adds DIV (three 32x32 partial products); div
//   waits in DIV, four quotient bits per pass through a row of four division cells, sixteen passes
// throughput: one word at a time, the next accepted after the result leaves
// reset: synchronous active-high, clears stack depth and control; stack
//   contents are not cleared
`default_nettype none
module stack_machine_alu
   import sma_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   sma_req_if.sink req,
   sma_rsp_if.source rsp
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_MUL = 3'd3;
   localparam logic [2:0] S_DIV = 3'd4;
   localparam logic [2:0] S_WB = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [4:0] func_ff;
   logic [WORD_W-1:0] pval_ff;
   logic [WORD_W-1:0] mem [STACK_DEPTH];
   logic [WORD_W-1:0] rd_top_ff, rd_sec_ff;
   logic [WORD_W-1:0] l_ff, r_ff, res_ff;
   logic [WORD_W-1:0] pp0_ff, pp1_ff, pp2_ff;
   logic neg_ff;
   logic [1:0] grp, wsel;
   logic [4:0] fm2;
   logic div_start, div_done;
   logic [WORD_W-1:0] div_q, ua, ub;
   logic [WORD_W-1:0] top_out_ff;
   logic [1:0] status_ff;
   logic wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [WORD_W-1:0] wr_data;

   assign fm2 = func_ff - 5'd2;
   assign grp = fm2[3:2];
   assign wsel = fm2[1:0];

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.top_value = top_out_ff;
   assign rsp.depth = 7'(count_ff);
   assign rsp.status = status_ff;

   // stack memory: two registered reads, one write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_top_ff <= mem[IDX_W'(count_ff - 1'b1)];
      rd_sec_ff <= mem[IDX_W'(count_ff - 2'd2)];
   end

   assign ua = l_ff[WORD_W-1] ? -l_ff : l_ff;
   assign ub = r_ff[WORD_W-1] ? -r_ff : r_ff;

   sma_div_chain u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(ua),
      .divisor(ub),
      .done(div_done),
      .quotient(div_q)
   );

   always_comb begin
      div_start = 1'b0;
      wr_en = 1'b0;
      wr_idx = IDX_W'(count_ff);
      wr_data = pval_ff;
      if (state_ff == S_READ && func_ff == FUNC_PUSH && count_ff < CNT_W'(STACK_DEPTH)) begin
         wr_en = 1'b1;
      end
      if (state_ff == S_WB) begin
         wr_en = 1'b1;
         wr_idx = IDX_W'(count_ff - 2'd2);
         wr_data = res_ff;
      end
      // operands are in l_ff and r_ff by now
      if (state_ff == S_MUL && grp == GRP_DIV) begin
         div_start = 1'b1;
      end
   end

   function automatic logic [WORD_W-1:0] fin(input logic [WORD_W-1:0] x,
                                            input logic [1:0] w);
      begin
         return (w == 2'd3) ? x : sext_w(x, 2'd2);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  func_ff <= req.func;
                  pval_ff <= req.push_value;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               // memory reads land this cycle
               status_ff <= ST_OK;
               state_ff <= S_OUT;
               if (func_ff == FUNC_PUSH) begin
                  if (count_ff < CNT_W'(STACK_DEPTH)) begin
                     count_ff <= count_ff + 1'b1;
                     top_out_ff <= pval_ff;
                  end else begin
                     status_ff <= ST_OVER;
                     state_ff <= S_EXEC;
                  end
               end else begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               top_out_ff <= (count_ff == '0) ? '0 : rd_top_ff;
               state_ff <= S_OUT;
               if (func_ff == FUNC_POP) begin
                  if (count_ff == '0) begin
                     status_ff <= ST_UNDER;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                  end
               end else if (func_ff != FUNC_PUSH && func_ff <= FUNC_LAST) begin
                  if (count_ff < CNT_W'(2)) begin
                     status_ff <= ST_UNDER;
                  end else begin
                     l_ff <= sext_w(rd_sec_ff, wsel);
                     r_ff <= sext_w(rd_top_ff, wsel);
                     state_ff <= S_MUL;
                     if (grp == GRP_DIV && sext_w(rd_top_ff, wsel) == '0) begin
                        status_ff <= ST_DIVZ;
                        state_ff <= S_OUT;
                     end
                  end
               end
            end
            S_MUL: begin
               neg_ff <= l_ff[WORD_W-1] ^ r_ff[WORD_W-1];
               pp0_ff <= l_ff[31:0] * r_ff[31:0];
               pp1_ff <= {32'd0, l_ff[63:32] * r_ff[31:0]};
               pp2_ff <= {32'd0, l_ff[31:0] * r_ff[63:32]};
               case (grp)
                  GRP_ADD: begin res_ff <= fin(l_ff + r_ff, wsel); state_ff <= S_WB; end
                  GRP_SUB: begin res_ff <= fin(l_ff - r_ff, wsel); state_ff <= S_WB; end
                  GRP_MUL: state_ff <= S_DIV;
                  default: state_ff <= S_DIV;
               endcase
            end
            S_DIV: begin
               if (grp == GRP_MUL) begin
                  res_ff <= fin(pp0_ff + {pp1_ff[31:0] + pp2_ff[31:0], 32'd0}, wsel);
                  state_ff <= S_WB;
               end else if (div_done) begin
                  res_ff <= fin(neg_ff ? -div_q : div_q, wsel);
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               count_ff <= count_ff - 1'b1;
               top_out_ff <= res_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/sma_checker.sv */
`default_nettype none
module sma_checker
   import sma_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [6:0] rsp_depth,
   input wire logic [1:0] rsp_status
);
   // a word in flight blocks new input
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepted while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depth))
      else $error("result dropped");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth <= 7'(STACK_DEPTH)) else $error("depth too large");
   a_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVER |-> rsp_depth == 7'(STACK_DEPTH))
      else $error("overflow below full");
endmodule

bind stack_machine_alu sma_checker u_sma_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_depth(rsp.depth),
   .rsp_status(rsp.status)
);
`default_nettype wire
